// ===== hw/rtl/plin_pkg.sv =====
// Shared types, constants and helpers of the piecewise-linear interpolator.
`default_nettype none
package plin_pkg;
   localparam int unsigned TABLE_DEPTH = 64;
   localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
   localparam int unsigned CNT_W       = IDX_W + 1;
   localparam int unsigned VAL_W       = 32;
   localparam int unsigned ENTRY_W     = 3 * VAL_W;
   localparam logic [VAL_W-1:0] PAD_RECIP = 32'h6666_6667;
   localparam int unsigned PAD_SHIFT   = 33;

   typedef enum logic [1:0] {
      ACT_LOAD  = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   typedef struct packed {
      logic start;
      logic div_only;
   } unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   function automatic logic [VAL_W-1:0] sat34(input logic signed [VAL_W+1:0] v);
      logic signed [VAL_W+1:0] hi;
      logic signed [VAL_W+1:0] lo;
      hi = (VAL_W+2)'(signed'({1'b0, {(VAL_W-1){1'b1}}}));
      lo = -hi - (VAL_W+2)'(1);
      if (v > hi) begin
         return {1'b0, {(VAL_W-1){1'b1}}};
      end else if (v < lo) begin
         return {1'b1, {(VAL_W-1){1'b0}}};
      end
      return v[VAL_W-1:0];
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/piecewise_linear_interpolator_core.sv =====
// Top level: breakpoint table, scan sequencer, range tracking and result register.
//
//  Channel  Direction  tdata                                   tuser
//  req      in         x_value, y1_value, y2_value (96 bits)   action
//  rsp      out        y1_at_x, y2_at_x, six padded bounds     status
//
// Clear, a load into a full table and an unused action go straight from idle to the done state.
// A load pads each of the three ranges in turn by reciprocal multiplication.
// A query scans the points in turn, then interpolates with two multiply-divide passes or clamps.
// Reset clears the table count, the ranges and the result valid flag; no clearing pass runs.
// The input is taken only while the sequencer is idle; a finished word waits until the
// result register is free.
`default_nettype none
module piecewise_linear_interpolator_core import plin_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [95:0]  req_tdata,   // x_value, y1_value, y2_value
   input  wire logic [1:0]   req_tuser,   // action
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [255:0] rsp_tdata,   // y1_at_x, y2_at_x, x_low, x_high, y1_low,
                                          // y1_high, y2_low, y2_high (padded)
   output logic      [1:0]   rsp_tuser    // status
);
   typedef enum logic [13:0] {
      S_IDLE      = 14'b00000000000001,
      S_SCAN_RD   = 14'b00000000000010,
      S_SCAN_CHK  = 14'b00000000000100,
      S_CLAMP_RD  = 14'b00000000001000,
      S_CLAMP_LAT = 14'b00000000010000,
      S_Y0_RD     = 14'b00000000100000,
      S_Y0_LAT    = 14'b00000001000000,
      S_Y1_RD     = 14'b00000010000000,
      S_Y1_LAT    = 14'b00000100000000,
      S_CURVE1    = 14'b00001000000000,
      S_CURVE2    = 14'b00010000000000,
      S_PAD_GO    = 14'b00100000000000,
      S_PAD_WAIT  = 14'b01000000000000,
      S_DONE      = 14'b10000000000000
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [1:0]              sel_ff, sel_in;
   logic signed [VAL_W-1:0] qx_ff, qx_in, prevx_ff, prevx_in;
   logic signed [VAL_W-1:0] min_ff [3], min_in [3], max_ff [3], max_in [3];
   logic [VAL_W-1:0]        padlo_ff [3], padlo_in [3], padhi_ff [3], padhi_in [3];
   logic [1:0]              status_ff, status_in;
   logic [VAL_W-1:0]        r1_ff, r1_in, r2_ff, r2_in, y1a_ff, y1a_in, y2a_ff, y2a_in;
   logic [VAL_W-1:0]        dx_ff, dx_in, t_ff, t_in, dy2mag_ff, dy2mag_in;
   logic                    dy1neg_ff, dy1neg_in, dy2neg_ff, dy2neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [255:0]            rsp_data_ff, rsp_data_in;
   logic [1:0]              rsp_user_ff, rsp_user_in;
   logic [VAL_W-1:0]        pad_ff, pad_in;

   logic                    accept, wr_en, load_out;
   logic [ENTRY_W-1:0]      rd_data;
   logic signed [VAL_W-1:0] xr, in_val [3];
   logic signed [VAL_W:0]   dx33, dy1, dy2;
   logic [VAL_W-1:0]        span;
   logic [VAL_W-3:0]        pad_n;
   logic [2*VAL_W-3:0]      pad_prod;
   logic signed [VAL_W+1:0] lo_sum, hi_sum;
   unit_cmd_type            ucmd;
   unit_stat_type           ustat;
   logic [VAL_W-1:0]        u_a, u_b, u_d, quot;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid & req_tready;
   assign in_val[0]  = req_tdata[31:0];
   assign in_val[1]  = req_tdata[63:32];
   assign in_val[2]  = req_tdata[95:64];
   assign wr_en      = accept & (action_type'(req_tuser) == ACT_LOAD)
                       & (count_ff < CNT_W'(TABLE_DEPTH));

   plin_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   plin_muldiv u_unit (
      .clock    (clock),
      .reset    (reset),
      .cmd      (ucmd),
      .op_a     (u_a),
      .op_b     (u_b),
      .op_d     (u_d),
      .stat     (ustat),
      .quotient (quot)
   );

   assign xr   = rd_data[31:0];
   assign dx33 = {xr[VAL_W-1], xr} - {prevx_ff[VAL_W-1], prevx_ff};
   assign dy1  = {rd_data[63], rd_data[63:32]} - {y1a_ff[VAL_W-1], y1a_ff};
   assign dy2  = {rd_data[95], rd_data[95:64]} - {y2a_ff[VAL_W-1], y2a_ff};
   assign span = VAL_W'({max_ff[sel_ff][VAL_W-1], max_ff[sel_ff]}
                        - {min_ff[sel_ff][VAL_W-1], min_ff[sel_ff]});
   assign pad_n    = span[VAL_W-1:2];
   assign pad_prod = {{VAL_W{1'b0}}, pad_n} * {{(VAL_W-2){1'b0}}, PAD_RECIP};
   assign pad_in   = VAL_W'(pad_prod >> PAD_SHIFT);
   assign lo_sum = {{2{min_ff[sel_ff][VAL_W-1]}}, min_ff[sel_ff]} - {2'b00, pad_ff};
   assign hi_sum = {{2{max_ff[sel_ff][VAL_W-1]}}, max_ff[sel_ff]} + {2'b00, pad_ff};
   assign load_out = (state_ff == S_DONE) & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      sel_in    = sel_ff;
      qx_in     = qx_ff;
      prevx_in  = prevx_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      padlo_in  = padlo_ff;
      padhi_in  = padhi_ff;
      status_in = status_ff;
      r1_in     = r1_ff;
      r2_in     = r2_ff;
      y1a_in    = y1a_ff;
      y2a_in    = y2a_ff;
      dx_in     = dx_ff;
      t_in      = t_ff;
      dy2mag_in = dy2mag_ff;
      dy1neg_in = dy1neg_ff;
      dy2neg_in = dy2neg_ff;
      ucmd      = '0;
      u_a       = '0;
      u_b       = t_ff;
      u_d       = dx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               qx_in     = in_val[0];
               status_in = STAT_OK;
               r1_in     = '0;
               r2_in     = '0;
               state_in  = S_DONE;
               unique case (action_type'(req_tuser))
                  ACT_LOAD: begin
                     if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                        status_in = STAT_FULL;
                     end else begin
                        for (int k = 0; k < 3; k++) begin
                           if (count_ff == '0 || in_val[k] < min_ff[k]) begin
                              min_in[k] = in_val[k];
                           end
                           if (count_ff == '0 || in_val[k] > max_ff[k]) begin
                              max_in[k] = in_val[k];
                           end
                        end
                        count_in = count_ff + CNT_W'(1);
                        sel_in   = '0;
                        state_in = S_PAD_GO;
                     end
                  end
                  ACT_CLEAR: begin
                     count_in = '0;
                     for (int k = 0; k < 3; k++) begin
                        min_in[k]   = '0;
                        max_in[k]   = '0;
                        padlo_in[k] = '0;
                        padhi_in[k] = '0;
                     end
                  end
                  ACT_QUERY: begin
                     if (count_ff == '0) begin
                        status_in = STAT_EMPTY;
                     end else begin
                        idx_in   = '0;
                        state_in = S_SCAN_RD;
                     end
                  end
                  ACT_NONE: begin
                     status_in = STAT_OK;
                  end
               endcase
            end
         end
         S_SCAN_RD: begin
            state_in = S_SCAN_CHK;
         end
         S_SCAN_CHK: begin
            priority if (idx_ff == '0 && qx_ff < xr) begin
               state_in = S_CLAMP_RD;
            end else if (idx_ff != '0 && xr >= qx_ff) begin
               idx_in = idx_ff - IDX_W'(1);
               if (dx33 <= 0 || qx_ff <= prevx_ff) begin
                  state_in = S_CLAMP_RD;
               end else begin
                  dx_in    = dx33[VAL_W-1:0];
                  t_in     = qx_ff - prevx_ff;
                  state_in = S_Y0_RD;
               end
            end else if ({1'b0, idx_ff} == count_ff - CNT_W'(1)) begin
               state_in = S_CLAMP_RD;
            end else begin
               prevx_in = xr;
               idx_in   = idx_ff + IDX_W'(1);
               state_in = S_SCAN_RD;
            end
         end
         S_CLAMP_RD: begin
            state_in = S_CLAMP_LAT;
         end
         S_CLAMP_LAT: begin
            r1_in    = rd_data[63:32];
            r2_in    = rd_data[95:64];
            state_in = S_DONE;
         end
         S_Y0_RD: begin
            state_in = S_Y0_LAT;
         end
         S_Y0_LAT: begin
            y1a_in   = rd_data[63:32];
            y2a_in   = rd_data[95:64];
            idx_in   = idx_ff + IDX_W'(1);
            state_in = S_Y1_RD;
         end
         S_Y1_RD: begin
            state_in = S_Y1_LAT;
         end
         S_Y1_LAT: begin
            dy1neg_in  = dy1[VAL_W];
            dy2neg_in  = dy2[VAL_W];
            dy2mag_in  = dy2[VAL_W] ? VAL_W'(-dy2) : dy2[VAL_W-1:0];
            u_a        = dy1[VAL_W] ? VAL_W'(-dy1) : dy1[VAL_W-1:0];
            ucmd.start = 1'b1;
            state_in   = S_CURVE1;
         end
         S_CURVE1: begin
            if (ustat.done) begin
               r1_in      = dy1neg_ff ? (y1a_ff - quot) : (y1a_ff + quot);
               u_a        = dy2mag_ff;
               ucmd.start = 1'b1;
               state_in   = S_CURVE2;
            end
         end
         S_CURVE2: begin
            if (ustat.done) begin
               r2_in    = dy2neg_ff ? (y2a_ff - quot) : (y2a_ff + quot);
               state_in = S_DONE;
            end
         end
         S_PAD_GO: begin
            if (!ustat.busy) begin
               state_in = S_PAD_WAIT;
            end
         end
         S_PAD_WAIT: begin
            padlo_in[sel_ff] = sat34(lo_sum);
            padhi_in[sel_ff] = sat34(hi_sum);
            if (sel_ff == 2'd2) begin
               state_in = S_DONE;
            end else begin
               sel_in   = sel_ff + 2'd1;
               state_in = S_PAD_GO;
            end
         end
         S_DONE: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = (rsp_valid_ff & ~rsp_tready) | load_out;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (load_out) begin
         rsp_data_in = {padhi_ff[2], padlo_ff[2], padhi_ff[1], padlo_ff[1],
                        padhi_ff[0], padlo_ff[0], r2_ff, r1_ff};
         rsp_user_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            min_ff[k]   <= '0;
            max_ff[k]   <= '0;
            padlo_ff[k] <= '0;
            padhi_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         padlo_ff     <= padlo_in;
         padhi_ff     <= padhi_in;
      end
      idx_ff      <= idx_in;
      sel_ff      <= sel_in;
      qx_ff       <= qx_in;
      prevx_ff    <= prevx_in;
      status_ff   <= status_in;
      r1_ff       <= r1_in;
      r2_ff       <= r2_in;
      y1a_ff      <= y1a_in;
      y2a_ff      <= y2a_in;
      dx_ff       <= dx_in;
      t_ff        <= t_in;
      dy2mag_ff   <= dy2mag_in;
      dy1neg_ff   <= dy1neg_in;
      dy2neg_ff   <= dy2neg_in;
      pad_ff      <= pad_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/plin_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module plin_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/plin_muldiv.sv =====
// Bit-serial multiply then divide around one shared adder: (a * b) / d, or a / d in divide-only mode.
`default_nettype none
module plin_muldiv import plin_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire unit_cmd_type     cmd,
   input  wire logic [VAL_W-1:0] op_a,
   input  wire logic [VAL_W-1:0] op_b,
   input  wire logic [VAL_W-1:0] op_d,
   output unit_stat_type         stat,
   output logic      [VAL_W-1:0] quotient
);
   typedef enum logic [2:0] {
      U_IDLE = 3'b001,
      U_MUL  = 3'b010,
      U_DIV  = 3'b100
   } ustate_type;

   localparam int unsigned STEP_W = $clog2(VAL_W);

   ustate_type        state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [VAL_W-1:0]  hi_ff, hi_in, lo_ff, lo_in, a_ff, a_in, d_ff, d_in;
   logic              done_ff, done_in;
   logic [VAL_W+1:0]  opa, opb, sum;
   logic              cin, ge;

   always_comb begin
      opa = '0;
      opb = '0;
      cin = 1'b0;
      unique case (state_ff)
         U_MUL: begin
            opa = {2'b00, hi_ff};
            opb = {2'b00, (lo_ff[0] ? a_ff : '0)};
         end
         U_DIV: begin
            opa = {1'b0, hi_ff, lo_ff[VAL_W-1]};
            opb = ~{2'b00, d_ff};
            cin = 1'b1;
         end
         default: begin
            opa = '0;
         end
      endcase
      sum = opa + opb + {{(VAL_W+1){1'b0}}, cin};
      ge  = ~sum[VAL_W+1];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      a_in     = a_ff;
      d_in     = d_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         U_IDLE: begin
            if (cmd.start) begin
               a_in   = op_a;
               d_in   = op_d;
               hi_in  = '0;
               cnt_in = '1;
               if (cmd.div_only) begin
                  lo_in    = op_a;
                  state_in = U_DIV;
               end else begin
                  lo_in    = op_b;
                  state_in = U_MUL;
               end
            end
         end
         U_MUL: begin
            hi_in  = sum[VAL_W:1];
            lo_in  = {sum[0], lo_ff[VAL_W-1:1]};
            cnt_in = cnt_ff - STEP_W'(1);
            if (cnt_ff == '0) begin
               state_in = U_DIV;
               cnt_in   = '1;
            end
         end
         U_DIV: begin
            hi_in  = ge ? sum[VAL_W-1:0] : {hi_ff[VAL_W-2:0], lo_ff[VAL_W-1]};
            lo_in  = {lo_ff[VAL_W-2:0], ge};
            cnt_in = cnt_ff - STEP_W'(1);
            if (cnt_ff == '0) begin
               state_in = U_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      a_ff   <= a_in;
      d_ff   <= d_in;
   end

   assign stat.busy = (state_ff != U_IDLE);
   assign stat.done = done_ff;
   assign quotient  = lo_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/plin_checker.sv =====
// Port-level checks on the interpolator, bound to the top level.
`default_nettype none
module plin_checker import plin_pkg::*; (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [255:0] rsp_tdata,
   input wire logic [1:0]   rsp_tuser
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken again before the word was processed");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == STAT_OK || rsp_tuser == STAT_FULL
                     || rsp_tuser == STAT_EMPTY)
      else $error("status code out of range");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STAT_EMPTY |-> rsp_tdata == '0)
      else $error("empty-table result carries data");
endmodule

bind piecewise_linear_interpolator_core plin_checker u_plin_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
